>>> hdl/adaptive_traffic_light_controller_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the adaptive traffic light controller
// Shared helpers for concurrent checks.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_TRAFFIC_LIGHT_CONTROLLER_DEFINES_SVH
`define ADAPTIVE_TRAFFIC_LIGHT_CONTROLLER_DEFINES_SVH

// check outside reset
`define ATLC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check that also holds during reset
`define ATLC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/atlc_pkg.sv
// ----------------------------------------------------------------------------
// atlc_pkg
// Types and constants of the adaptive traffic light controller.
// ----------------------------------------------------------------------------
package atlc_pkg;

  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ElapW   = 10;
  localparam int unsigned CntW    = 8;
  localparam int unsigned TimerW  = 17;
  localparam int unsigned PhaseW  = 2;
  localparam int unsigned TotW    = CntW + 1;
  localparam int unsigned ProdW   = CntW + CfgW;
  localparam int unsigned DivCntW = 4;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 24;

  localparam logic [TimerW-1:0] TimerMax = '1;

  localparam logic [CfgIdxW-1:0] RegMinGreen  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMaxGreen  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegBaseGreen = 2'd2;
  localparam logic [CfgIdxW-1:0] RegYellow    = 2'd3;

  localparam logic [CfgW-1:0] MinGreenRst  = 16'd4000;
  localparam logic [CfgW-1:0] MaxGreenRst  = 16'd22000;
  localparam logic [CfgW-1:0] BaseGreenRst = 16'd10000;
  localparam logic [CfgW-1:0] YellowRst    = 16'd2000;

  localparam logic [PhaseW-1:0] PhNsGreen  = 2'd0;
  localparam logic [PhaseW-1:0] PhNsYellow = 2'd1;
  localparam logic [PhaseW-1:0] PhEwGreen  = 2'd2;
  localparam logic [PhaseW-1:0] PhEwYellow = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } status_t;

endpackage

>>> hdl/adaptive_traffic_light_controller.sv
// Flow: load, 16 divider steps on a green phase with vehicles present and no
// preemption, commit; the commit waits while an untaken result is held.
// Throughput: one request at a time, set by the 1-bit-per-cycle restoring
// divider; a finished result waits in the output register.
// Reset: asynchronous, active low; NS green, timer zero, config to defaults.
// ----------------------------------------------------------------------------
// adaptive_traffic_light_controller
// Four-phase signal controller with load-adaptive green time and preemption.
// ----------------------------------------------------------------------------
module adaptive_traffic_light_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [atlc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [atlc_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // elapsed_ms[9:0], ns_count[17:10], ew_count[25:18],
  // ns_ambulance[26], ew_ambulance[27], zero pad
  input  logic [atlc_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // light_phase[1:0], phase_time_ms[18:2], zero pad
  output logic [atlc_pkg::OutDataW-1:0] m_axis_tdata
);

  atlc_pkg::cmd_t    cmd;
  atlc_pkg::status_t status;

  atlc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  atlc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata),
    .out_data_o (m_axis_tdata),
    .cmd_i      (cmd),
    .status_o   (status)
  );

endmodule

>>> hdl/atlc_ctrl.sv
// ----------------------------------------------------------------------------
// atlc_ctrl
// Sequencer: request intake, divider stepping, result commit, output valid.
// ----------------------------------------------------------------------------
module atlc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  atlc_pkg::status_t status_i,
  output atlc_pkg::cmd_t    cmd_o
);

  atlc_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= atlc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      atlc_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_d = atlc_pkg::ST_DIV;
      end
      atlc_pkg::ST_DIV: begin
        if (!status_i.need_div || status_i.div_last) state_d = atlc_pkg::ST_DONE;
      end
      atlc_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready) state_d = atlc_pkg::ST_IDLE;
      end
      default: state_d = atlc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      atlc_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.load    = s_axis_tvalid;
      end
      atlc_pkg::ST_DIV: begin
        cmd_o.div_step = status_i.need_div;
      end
      atlc_pkg::ST_DONE: begin
        cmd_o.commit = !out_valid_q || m_axis_tready;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;

endmodule

>>> hdl/atlc_dp.sv
// ----------------------------------------------------------------------------
// atlc_dp
// Datapath: config registers, phase state, green-time multiply and
// restoring divider, limit compare and result register.
// ----------------------------------------------------------------------------
module atlc_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [atlc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [atlc_pkg::CfgW-1:0]      cfg_data_i,
  input  logic [atlc_pkg::InDataW-1:0]   in_data_i,
  output logic [atlc_pkg::OutDataW-1:0]  out_data_o,
  input  atlc_pkg::cmd_t                 cmd_i,
  output atlc_pkg::status_t              status_o
);

  localparam int unsigned TW = atlc_pkg::TimerW;
  localparam int unsigned CW = atlc_pkg::CfgW;

  logic [CW-1:0] min_q, max_q, base_q, yellow_q;
  logic [atlc_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [TW-1:0] timer_q, timer_d;

  logic [atlc_pkg::ElapW-1:0] in_elap;
  logic [atlc_pkg::CntW-1:0]  in_ns, in_ew, in_cnt;
  logic                       in_ns_amb, in_ew_amb;
  logic [CW-1:0]              span;
  logic [TW:0]                sum_wide;

  logic [TW-1:0]              tsum_q;
  logic [atlc_pkg::TotW-1:0]  tot_q;
  logic                       preempt_q;
  logic [atlc_pkg::PhaseW-1:0] pre_phase_q;
  logic [atlc_pkg::TotW-1:0]  rem_q, rem_d;
  logic [CW-1:0]              dvd_q, dvd_d;
  logic [atlc_pkg::DivCntW-1:0] cnt_q;
  logic [atlc_pkg::TotW:0]    trial;
  logic [atlc_pkg::ProdW-1:0] prod;

  logic                       green;
  logic [TW-1:0]              limit;
  logic [atlc_pkg::PhaseW-1:0] out_phase_q;
  logic [TW-1:0]              out_time_q;

  assign in_elap   = in_data_i[9:0];
  assign in_ns     = in_data_i[17:10];
  assign in_ew     = in_data_i[25:18];
  assign in_ns_amb = in_data_i[26];
  assign in_ew_amb = in_data_i[27];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= atlc_pkg::MinGreenRst;
      max_q    <= atlc_pkg::MaxGreenRst;
      base_q   <= atlc_pkg::BaseGreenRst;
      yellow_q <= atlc_pkg::YellowRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        atlc_pkg::RegMinGreen:  min_q    <= cfg_data_i;
        atlc_pkg::RegMaxGreen:  max_q    <= cfg_data_i;
        atlc_pkg::RegBaseGreen: base_q   <= cfg_data_i;
        atlc_pkg::RegYellow:    yellow_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign span     = (max_q >= min_q) ? (max_q - min_q) : '0;
  assign in_cnt   = (phase_q == atlc_pkg::PhEwGreen) ? in_ew : in_ns;
  assign prod     = in_cnt * span;
  assign sum_wide = {1'b0, timer_q} + {{(TW + 1 - atlc_pkg::ElapW){1'b0}}, in_elap};
  assign green    = (phase_q == atlc_pkg::PhNsGreen) || (phase_q == atlc_pkg::PhEwGreen);

  // restoring divide step, quotient bits shift in from the bottom
  assign trial = {rem_q, dvd_q[CW-1]};

  always_comb begin
    rem_d = rem_q;
    dvd_d = dvd_q;
    if (cmd_i.load) begin
      rem_d = {1'b0, prod[atlc_pkg::ProdW-1:CW]};
      dvd_d = prod[CW-1:0];
    end else if (cmd_i.div_step) begin
      if (trial >= {1'b0, tot_q}) begin
        rem_d = atlc_pkg::TotW'(trial - {1'b0, tot_q});
        dvd_d = {dvd_q[CW-2:0], 1'b1};
      end else begin
        rem_d = trial[atlc_pkg::TotW-1:0];
        dvd_d = {dvd_q[CW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    if (cmd_i.load) begin
      tsum_q      <= sum_wide[TW] ? atlc_pkg::TimerMax : sum_wide[TW-1:0];
      tot_q       <= {1'b0, in_ns} + {1'b0, in_ew};
      preempt_q   <= in_ns_amb ^ in_ew_amb;
      pre_phase_q <= in_ns_amb ? atlc_pkg::PhNsGreen : atlc_pkg::PhEwGreen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign status_o.need_div = !preempt_q && green && (tot_q != '0);
  assign status_o.div_last = (cnt_q == '1);

  always_comb begin
    if (!green) begin
      limit = {1'b0, yellow_q};
    end else if (tot_q == '0) begin
      limit = {1'b0, base_q};
    end else begin
      limit = {1'b0, min_q} + {1'b0, dvd_q};
    end
  end

  always_comb begin
    phase_d = phase_q;
    timer_d = timer_q;
    if (cmd_i.commit) begin
      if (preempt_q) begin
        phase_d = pre_phase_q;
        timer_d = '0;
      end else if (tsum_q > limit) begin
        phase_d = phase_q + 1'b1;
        timer_d = '0;
      end else begin
        timer_d = tsum_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= atlc_pkg::PhNsGreen;
      timer_q <= '0;
    end else begin
      phase_q <= phase_d;
      timer_q <= timer_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_phase_q <= phase_d;
      out_time_q  <= timer_d;
    end
  end

  assign out_data_o = {{(atlc_pkg::OutDataW - TW - atlc_pkg::PhaseW){1'b0}},
                       out_time_q, out_phase_q};

endmodule

>>> hdl/atlc_checker.sv
// ----------------------------------------------------------------------------
// atlc_checker
// Port-level checks for the adaptive traffic light controller.
// ----------------------------------------------------------------------------
`include "adaptive_traffic_light_controller_defines.svh"

module atlc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [atlc_pkg::OutDataW-1:0] m_axis_tdata
);

  `ATLC_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result changed while stalled")

  `ATLC_ASSERT(a_one_at_a_time, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request taken while one is in work")

  `ATLC_ASSERT(a_result_after_work, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "result appeared without a request in work")

  `ATLC_ASSERT_ALWAYS(a_reset_clear, clk_i, !rst_ni |-> !m_axis_tvalid, "result valid during reset")

endmodule

bind adaptive_traffic_light_controller atlc_checker u_atlc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
